// ===== rtl/core/cubic_bspline_segment_evaluator_unit_macros.svh =====
// Assertion macros shared by the B-spline evaluator RTL.
// Depends on nothing; the using module supplies clk and arst_n.
`ifndef CUBIC_BSPLINE_SEGMENT_EVALUATOR_UNIT_MACROS_SVH
`define CUBIC_BSPLINE_SEGMENT_EVALUATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/cbs_pkg.sv =====
// Shared types and constants of the cubic B-spline segment evaluator.
// No dependencies; used by the top level and by anything that drives its channels.
`default_nettype none

package cbs_pkg;

	localparam int XW = 16;
	localparam int KW = 6;

	localparam logic KIND_POINT   = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	typedef logic signed [XW-1:0] coord_t;
	typedef logic [KW-1:0]        kidx_t;

	typedef struct packed {
		logic   kind;
		coord_t point_x;
		coord_t point_y;
	} in_item_t;

	typedef struct packed {
		coord_t curve_x;
		coord_t curve_y;
		kidx_t  sample_index;
		logic   last_of_segment;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/cbs_stream_if.sv =====
// Valid/ready stream channel carrying one item of a given type.
// No dependencies; the item type is set where the channel is instantiated.
`default_nettype none

interface cbs_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cubic_bspline_segment_evaluator_unit.sv =====
// Uniform cubic B-spline segment evaluator: point history, sample sequencer,
// exact rounded weighting pipeline and output skid stage.
// Depends on cbs_pkg, cbs_stream_if and the assertion macro header.
//
//  channel  | role   | item
//  ---------+--------+-----------------------------------------------------
//  points   | sink   | kind, point_x, point_y (cbs_pkg::in_item_t)
//  samples  | source | curve_x, curve_y, sample_index, last_of_segment
//
// A point that closes a window of four issues STEPS+1 samples, one per cycle while the skid register is empty,
// from the sample counter; any other item is taken without issuing samples.
// The next item is taken in the cycle that issues the last sample.
// Samples leave through five stages and the output register after issue.
// Reset clears the history, the point count and all valid flags.
// A stall on samples fills the skid register and then freezes the pipeline.
`default_nettype none
`include "cubic_bspline_segment_evaluator_unit_macros.svh"

module cubic_bspline_segment_evaluator_unit #(
	parameter int STEPS = 20
) (
	input  wire           clk,
	input  wire           arst_n,
	cbs_stream_if.sink    points,
	cbs_stream_if.source  samples
);

	localparam int XW = cbs_pkg::XW;
	localparam int KW = cbs_pkg::KW;

	localparam longint DEN   = 6 * longint'(STEPS) * longint'(STEPS) * longint'(STEPS);
	localparam int     DW    = $clog2(DEN + 1);
	localparam int     WW    = $clog2(4 * longint'(STEPS) ** 3 + 1);
	localparam int     NW    = XW + DW;
	localparam int     ACCW  = NW + 1;
	localparam int     PW    = WW + XW + 1;
	localparam longint BIAS  = DEN / 2 + 64'sd32768 * DEN;
	localparam longint RECIP = (longint'(1) << NW) / DEN;
	localparam int     MW    = $clog2(RECIP + 1);

	localparam logic [DW-1:0]   DEN_V   = DW'(DEN);
	localparam logic [NW-1:0]   DEN_N   = NW'(DEN);
	localparam logic [NW-1:0]   DEN2_N  = NW'(2 * DEN);
	localparam logic [ACCW-1:0] BIAS_V  = ACCW'(BIAS);
	localparam logic [MW-1:0]   RECIP_V = MW'(RECIP);
	localparam cbs_pkg::kidx_t  K_LAST  = KW'(STEPS);
	localparam logic [1:0]      SEEN_FULL = 2'd3;

	typedef logic [3:0][WW-1:0]             weights_t;
	typedef logic [2**KW-1:0][3:0][WW-1:0]  wtab_t;

	// Integer basis weights for every sample index; they sum to DEN.
	function automatic wtab_t build_wtab();
		wtab_t  tab;
		longint s;
		longint k;
		longint sk;
		tab = '0;
		s = longint'(STEPS);
		for (int i = 0; i <= STEPS; i++) begin
			k = longint'(i);
			sk = s - k;
			tab[i][0] = WW'(sk * sk * sk);
			tab[i][1] = WW'(3 * k * k * k - 6 * k * k * s + 4 * s * s * s);
			tab[i][2] = WW'(-3 * k * k * k + 3 * k * k * s + 3 * k * s * s + s * s * s);
			tab[i][3] = WW'(k * k * k);
		end
		return tab;
	endfunction

	localparam wtab_t WTAB = build_wtab();

	// ---------------------------------------------------------------- sequencer
	logic            busy_q;
	cbs_pkg::kidx_t  k_q;
	logic [1:0]      seen_q;
	cbs_pkg::coord_t hx_q [3];
	cbs_pkg::coord_t hy_q [3];
	cbs_pkg::coord_t win_x_q [4];
	cbs_pkg::coord_t win_y_q [4];

	logic skid_valid_q;
	logic adv;
	logic k_last;
	logic issue;
	logic take;
	logic opens_window;

	assign adv          = !skid_valid_q;
	assign k_last       = (k_q == K_LAST);
	assign issue        = busy_q && adv;
	assign points.ready = !busy_q || (adv && k_last);
	assign take         = points.valid && points.ready;
	assign opens_window = take && (points.data.kind == cbs_pkg::KIND_POINT)
		&& (seen_q == SEEN_FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			seen_q <= '0;
			hx_q   <= '{default: '0};
			hy_q   <= '{default: '0};
		end else begin
			// A new window can only open while idle or on the last sample.
			if (opens_window) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (issue) begin
				if (k_last) begin
					busy_q <= 1'b0;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			if (take) begin
				if (points.data.kind == cbs_pkg::KIND_RESTART) begin
					seen_q <= '0;
					hx_q   <= '{default: '0};
					hy_q   <= '{default: '0};
				end else begin
					hx_q[0] <= hx_q[1];
					hx_q[1] <= hx_q[2];
					hx_q[2] <= points.data.point_x;
					hy_q[0] <= hy_q[1];
					hy_q[1] <= hy_q[2];
					hy_q[2] <= points.data.point_y;
					if (seen_q != SEEN_FULL) begin
						seen_q <= seen_q + 1'b1;
					end
				end
			end
		end
	end

	// The window is captured before the history shifts, oldest point first.
	always_ff @(posedge clk) begin
		if (opens_window) begin
			win_x_q <= '{hx_q[0], hx_q[1], hx_q[2], points.data.point_x};
			win_y_q <= '{hy_q[0], hy_q[1], hy_q[2], points.data.point_y};
		end
	end

	// ---------------------------------------------------------------- pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	cbs_pkg::kidx_t k_s1, k_s2, k_s3, k_s4, k_s5;
	logic           last_s1, last_s2, last_s3, last_s4, last_s5;

	weights_t        w_s1;
	cbs_pkg::coord_t px_s1 [4];
	cbs_pkg::coord_t py_s1 [4];

	logic signed [PW-1:0] prx_s2 [4];
	logic signed [PW-1:0] pry_s2 [4];

	logic [NW-1:0]    nx_s3, ny_s3, nx_s4, ny_s4, nx_s5, ny_s5;
	logic [NW+MW-1:0] mx_s4, my_s4;
	logic [XW-1:0]    qx_s5, qy_s5;
	logic [NW-1:0]    dx_s5, dy_s5;

	logic [ACCW-1:0] acc_x;
	logic [ACCW-1:0] acc_y;

	// The bias adds the rounding half and lifts the sum so that it is never negative.
	assign acc_x = ACCW'(prx_s2[0]) + ACCW'(prx_s2[1]) + ACCW'(prx_s2[2])
		+ ACCW'(prx_s2[3]) + BIAS_V;
	assign acc_y = ACCW'(pry_s2[0]) + ACCW'(pry_s2[1]) + ACCW'(pry_s2[2])
		+ ACCW'(pry_s2[3]) + BIAS_V;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= busy_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1    <= k_q;
			last_s1 <= k_last;
			w_s1    <= WTAB[k_q];
			px_s1   <= win_x_q;
			py_s1   <= win_y_q;

			k_s2    <= k_s1;
			last_s2 <= last_s1;
			for (int i = 0; i < 4; i++) begin
				prx_s2[i] <= $signed({1'b0, w_s1[i]}) * px_s1[i];
				pry_s2[i] <= $signed({1'b0, w_s1[i]}) * py_s1[i];
			end

			k_s3    <= k_s2;
			last_s3 <= last_s2;
			nx_s3   <= acc_x[NW-1:0];
			ny_s3   <= acc_y[NW-1:0];

			// Quotient estimate by reciprocal; it is exact or one short.
			k_s4    <= k_s3;
			last_s4 <= last_s3;
			mx_s4   <= nx_s3 * RECIP_V;
			my_s4   <= ny_s3 * RECIP_V;
			nx_s4   <= nx_s3;
			ny_s4   <= ny_s3;

			k_s5    <= k_s4;
			last_s5 <= last_s4;
			qx_s5   <= mx_s4[NW +: XW];
			qy_s5   <= my_s4[NW +: XW];
			dx_s5   <= mx_s4[NW +: XW] * DEN_V;
			dy_s5   <= my_s4[NW +: XW] * DEN_V;
			nx_s5   <= nx_s4;
			ny_s5   <= ny_s4;
		end
	end

	logic [NW-1:0]       rx, ry;
	logic [XW-1:0]       qfx, qfy;
	cbs_pkg::out_item_t  res;

	assign rx  = nx_s5 - dx_s5;
	assign ry  = ny_s5 - dy_s5;
	assign qfx = qx_s5 + XW'(rx >= DEN_N);
	assign qfy = qy_s5 + XW'(ry >= DEN_N);

	// Removing the lift of 32768 is an inversion of the top bit.
	always_comb begin
		res.curve_x         = {~qfx[XW-1], qfx[XW-2:0]};
		res.curve_y         = {~qfy[XW-1], qfy[XW-2:0]};
		res.sample_index    = k_s5;
		res.last_of_segment = last_s5;
	end

	// ---------------------------------------------------------------- output skid
	logic               out_valid_q;
	cbs_pkg::out_item_t out_q;
	cbs_pkg::out_item_t skid_q;
	logic               push;
	logic               out_free;

	assign push     = adv && v_s5;
	assign out_free = samples.ready || !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (samples.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign samples.valid = out_valid_q;
	assign samples.data  = out_q;

	// ---------------------------------------------------------------- checks
	`CBS_ASSERT_SAME(a_skid_behind_out, skid_valid_q, out_valid_q, "skid holds an item while the output register is empty")
	`CBS_ASSERT_NEXT(a_count_steps, issue && !k_last, busy_q && (k_q == $past(k_q) + 1'b1), "sample counter skipped or stalled during issue")
	`CBS_ASSERT_NEXT(a_segment_ends, issue && k_last, !busy_q || (k_q == '0), "segment did not end or restart after its last sample")
	`CBS_ASSERT_SAME(a_quotient_close, v_s5, (rx < DEN2_N) && (ry < DEN2_N), "reciprocal estimate off by more than one")

endmodule

`default_nettype wire
